@@ sv/log_compressed_sample_mixer_defines.svh @@
// Assertion macros for the sample mixer.
// Every module that uses them has ports named clock and reset.
`ifndef LOG_COMPRESSED_SAMPLE_MIXER_DEFINES_SVH
`define LOG_COMPRESSED_SAMPLE_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
`define LCSM_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcsm: same-cycle check failed");
`define LCSM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcsm: next-cycle check failed");
`else
`define LCSM_ASSERT_IMP(name, ante, cons)
`define LCSM_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ sv/lcsm_pkg.sv @@
`default_nettype none
package lcsm_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int LOG_TABLE_BITS_DEF = 6;

   localparam logic [63:0] ALPHA_Q16 = 64'd490431;
   localparam logic [63:0] ONE_Q16   = 64'd65536;
   localparam int ALPHA_W     = 19;
   localparam int FRAC_BITS   = 20;
   localparam int LG_W        = 19;
   localparam int ENTRY_W     = 17;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic neg;
      logic comp;
   } lcsm_class_type;

   // log2(1 + k/2^ltb) in Q16, bit by bit through repeated squaring
   function automatic logic [ENTRY_W-1:0] log2_frac_entry(input int unsigned k,
                                                          input int unsigned ltb);
      logic [63:0] z;
      logic [63:0] r;
      z = (64'd1 << 30) + (64'(k) << (30 - ltb));
      r = '0;
      if (z >= (64'd1 << 31)) return ENTRY_W'(ONE_Q16);
      for (int i = 0; i < FRAC_BITS; i++) begin
         z = (z * z) >> 30;
         r = r << 1;
         if (z >= (64'd1 << 31)) begin
            z = z >> 1;
            r[0] = 1'b1;
         end
      end
      return ENTRY_W'((r + 64'd8) >> 4);
   endfunction

   // elaboration-time log2 of a Q16 value, same interpolation as the datapath
   function automatic logic [LG_W-1:0] log2_q16_const(input logic [63:0] y,
                                                      input int unsigned ltb);
      int unsigned e;
      int unsigned rb;
      logic [63:0] frac;
      logic [63:0] idx;
      logic [63:0] rem;
      logic [63:0] lo;
      logic [63:0] hi;
      rb = FRAC_BITS - ltb;
      e  = 0;
      while (e < 3 && (y >> (17 + e)) != 64'd0) e++;
      frac = ((y << (4 - e)) - (64'd1 << FRAC_BITS)) & ((64'd1 << FRAC_BITS) - 64'd1);
      idx  = frac >> rb;
      rem  = frac & ((64'd1 << rb) - 64'd1);
      lo   = 64'(log2_frac_entry(32'(idx), ltb));
      hi   = 64'(log2_frac_entry(32'(idx) + 1, ltb));
      return LG_W'(64'(e) * ONE_Q16 + lo + (((hi - lo) * rem) >> rb));
   endfunction

endpackage
`default_nettype wire

@@ sv/lcsm_cdiv.sv @@
`default_nettype none
module lcsm_cdiv
   import lcsm_pkg::*;
#(
   parameter int          NUM_W   = 36,
   parameter int          QBITS   = ALPHA_W,
   parameter logic [63:0] DIVISOR = 64'd45875,
   parameter int          TAG_W   = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QBITS-1:0] out_quot,
   output logic [TAG_W-1:0] out_tag
);

   // floor(in_num / DIVISOR) = (in_num * RECIP) >> S_SH, RECIP = ceil(2^S_SH / DIVISOR);
   // exact for every NUM_W-bit numerator, product split into four partial products
   localparam int STAGES = 4;
   localparam int S_SH   = NUM_W + $clog2(DIVISOR);
   localparam int RC_W   = NUM_W + 2;
   localparam int H_W    = (NUM_W + 3) / 2;
   localparam int NH_W   = NUM_W - H_W;
   localparam int RH_W   = RC_W - H_W;
   localparam int HH_W   = NH_W + RH_W;
   localparam int LL_W   = 2 * H_W;
   localparam int X_W    = RC_W + 1;
   localparam int P_W    = NUM_W + RC_W;

   localparam logic [127:0] RECIP_WIDE =
      ((128'd1 << S_SH) - 128'd1) / 128'(DIVISOR) + 128'd1;
   localparam logic [RC_W-1:0] RECIP = RC_W'(RECIP_WIDE);
   localparam logic [H_W-1:0]  R_LO  = RECIP[H_W-1:0];
   localparam logic [RH_W-1:0] R_HI  = RECIP[RC_W-1:H_W];

   logic [STAGES-1:0] vld_ff;
   logic [TAG_W-1:0]  tag_ff [STAGES];
   logic [NUM_W-1:0]  num_ff;
   logic [HH_W-1:0]   hh_ff;
   logic [LL_W-1:0]   ll_ff;
   logic [NUM_W-1:0]  hl_ff;
   logic [RC_W-1:0]   lh_ff;
   logic [P_W-1:0]    cat_ff;
   logic [X_W-1:0]    cross_ff;
   logic [QBITS-1:0]  quot_ff;
   logic [NH_W-1:0]   n_hi;
   logic [H_W-1:0]    n_lo;
   logic [P_W-1:0]    total;

   assign n_hi  = num_ff[NUM_W-1:H_W];
   assign n_lo  = num_ff[H_W-1:0];
   assign total = cat_ff + (P_W'(cross_ff) << H_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= in_num;
      tag_ff[0] <= in_tag;
      for (int j = 0; j < STAGES - 1; j++) tag_ff[j+1] <= tag_ff[j];
      hh_ff     <= HH_W'(n_hi) * HH_W'(R_HI);
      ll_ff     <= LL_W'(n_lo) * LL_W'(R_LO);
      hl_ff     <= NUM_W'(n_hi) * NUM_W'(R_LO);
      lh_ff     <= RC_W'(n_lo) * RC_W'(R_HI);
      cat_ff    <= {hh_ff, ll_ff};
      cross_ff  <= X_W'(hl_ff) + X_W'(lh_ff);
      quot_ff   <= QBITS'(total >> S_SH);
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quot  = quot_ff;
   assign out_tag   = tag_ff[STAGES-1];

endmodule
`default_nettype wire

@@ sv/lcsm_front.sv @@
`default_nettype none
`include "log_compressed_sample_mixer_defines.svh"
module lcsm_front
   import lcsm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_acc_sample,
   input  logic                           req_acc_present,
   input  logic signed [SAMPLE_WIDTH-1:0] req_source_sample,
   output logic                           out_valid,
   output lcsm_class_type                 out_class,
   output logic [SAMPLE_WIDTH:0]          out_mag,
   output logic [SAMPLE_WIDTH-1:0]        out_diff,
   input  logic                           out_full
);

   localparam logic [63:0] FULL   = 64'd1 << (SAMPLE_WIDTH - 1);
   localparam logic [63:0] THRESH = (FULL * 6 + 5) / 10;
   localparam logic [SAMPLE_WIDTH:0] THRESH_M = (SAMPLE_WIDTH+1)'(THRESH);

   logic                  f1_vld_ff, f1_vld_in, f1_en;
   logic [SAMPLE_WIDTH:0] sum_ff, sum_in;
   logic                  f2_vld_ff, f2_vld_in, f2_en;
   lcsm_class_type        cls_ff, cls_in;
   logic [SAMPLE_WIDTH:0] mag_ff, mag_in, over;
   logic [SAMPLE_WIDTH-1:0] diff_ff, diff_in;
   logic                  accept;

   assign f2_en  = !f2_vld_ff || !out_full;
   assign f1_en  = !f1_vld_ff || f2_en;
   assign busy   = !f1_en;
   assign accept = start && !busy;

   always_comb begin
      sum_in = (req_acc_present ? (SAMPLE_WIDTH+1)'(req_acc_sample) : '0)
             + (SAMPLE_WIDTH+1)'(req_source_sample);
      f1_vld_in = f1_en ? accept : f1_vld_ff;
      f2_vld_in = f2_en ? f1_vld_ff : f2_vld_ff;
      cls_in.neg  = sum_ff[SAMPLE_WIDTH];
      mag_in      = cls_in.neg ? (SAMPLE_WIDTH+1)'(0) - sum_ff : sum_ff;
      over        = mag_in - THRESH_M;
      cls_in.comp = mag_in > THRESH_M;
      diff_in     = cls_in.comp ? over[SAMPLE_WIDTH-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_en) begin
         sum_ff <= sum_in;
      end
      if (f2_en) begin
         cls_ff  <= cls_in;
         mag_ff  <= mag_in;
         diff_ff <= diff_in;
      end
   end

   assign out_valid = f2_vld_ff;
   assign out_class = cls_ff;
   assign out_mag   = mag_ff;
   assign out_diff  = diff_ff;

   `LCSM_ASSERT_NEXT(a_accept_lands, accept, f1_vld_ff)

endmodule
`default_nettype wire

@@ sv/lcsm_queue.sv @@
`default_nettype none
`include "log_compressed_sample_mixer_defines.svh"
module lcsm_queue
   import lcsm_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             full,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_pop
);

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && !full;
   assign pop       = out_pop && out_valid;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   `LCSM_ASSERT_IMP(a_count_bound, 1'b1, cnt_ff <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

@@ sv/lcsm_back.sv @@
`default_nettype none
`include "log_compressed_sample_mixer_defines.svh"
module lcsm_back
   import lcsm_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  lcsm_class_type          in_class,
   input  logic [SAMPLE_WIDTH:0]   in_mag,
   input  logic [SAMPLE_WIDTH-1:0] in_diff,
   output logic                    in_pop,
   output logic                    out_valid,
   output logic [SAMPLE_WIDTH-1:0] out_sample
);

   localparam logic [63:0] FULL   = 64'd1 << (SAMPLE_WIDTH - 1);
   localparam logic [63:0] THRESH = (FULL * 6 + 5) / 10;
   localparam logic [63:0] SPAN   = 2 * FULL - THRESH;
   localparam logic [63:0] HEAD   = FULL - THRESH;
   localparam logic [63:0] YMAX   = ONE_Q16 + (ALPHA_Q16 * SPAN + SPAN / 2) / SPAN;
   localparam logic [LG_W-1:0] LGMAX = log2_q16_const(YMAX, LOG_TABLE_BITS);

   localparam int NUM1_W   = SAMPLE_WIDTH + ALPHA_W + 1;
   localparam int Q2_BITS  = SAMPLE_WIDTH - 1;
   localparam int NUM2_W   = Q2_BITS + LG_W + 1;
   localparam int REM_BITS = FRAC_BITS - LOG_TABLE_BITS;
   localparam int TAB_LEN  = (1 << LOG_TABLE_BITS) + 1;
   localparam int TI_W     = LOG_TABLE_BITS + 1;
   localparam int PROD_W   = ENTRY_W + REM_BITS;

   localparam logic [ALPHA_W-1:0]     ALPHA_M    = ALPHA_W'(ALPHA_Q16);
   localparam logic [NUM1_W-1:0]      HALF_SPAN  = NUM1_W'(SPAN / 2);
   localparam logic [Q2_BITS-1:0]     HEAD_M     = Q2_BITS'(HEAD);
   localparam logic [NUM2_W-1:0]      HALF_LGMAX = NUM2_W'(LGMAX / 2);
   localparam logic [SAMPLE_WIDTH:0]  THRESH_M   = (SAMPLE_WIDTH+1)'(THRESH);
   localparam logic [SAMPLE_WIDTH:0]  FULL_M     = (SAMPLE_WIDTH+1)'(FULL);
   localparam logic [SAMPLE_WIDTH:0]  POS_MAX    = (SAMPLE_WIDTH+1)'(FULL - 1);
   localparam logic [FRAC_BITS-1:0]   ONE_Y      = FRAC_BITS'(ONE_Q16);

   typedef struct packed {
      lcsm_class_type        cls;
      logic [SAMPLE_WIDTH:0] mag;
   } tag_type;

   // log2(1 + k/2^LOG_TABLE_BITS) in Q16
   logic [ENTRY_W-1:0] log_tab [TAB_LEN];
   for (genvar k = 0; k < TAB_LEN; k++) begin : g_tab
      localparam logic [ENTRY_W-1:0] ENTRY = log2_frac_entry(k, LOG_TABLE_BITS);
      assign log_tab[k] = ENTRY;
   end

   logic                    b1_vld_ff;
   logic [NUM1_W-1:0]       b1_num_ff, b1_num_in;
   tag_type                 b1_tag_ff, b1_tag_in;

   logic                    d1_valid;
   logic [ALPHA_W-1:0]      d1_quot;
   tag_type                 d1_tag;

   logic [FRAC_BITS-1:0]    y, frac;
   logic [1:0]              exp_in;
   logic [TI_W-1:0]         idx_lo, idx_hi;
   logic [ENTRY_W-1:0]      lo_in, hi_in;

   logic                    b2_vld_ff;
   logic [1:0]              b2_exp_ff;
   logic [ENTRY_W-1:0]      b2_lo_ff, b2_slope_ff;
   logic [REM_BITS-1:0]     b2_rem_ff;
   tag_type                 b2_tag_ff;

   logic                    b3_vld_ff;
   logic [1:0]              b3_exp_ff;
   logic [ENTRY_W-1:0]      b3_lo_ff;
   logic [PROD_W-1:0]       b3_prod_ff;
   tag_type                 b3_tag_ff;

   logic                    b4_vld_ff;
   logic [LG_W-1:0]         b4_lg_ff, b4_lg_in;
   tag_type                 b4_tag_ff;

   logic                    b5_vld_ff;
   logic [NUM2_W-1:0]       b5_num_ff, b5_num_in;
   tag_type                 b5_tag_ff;

   logic                    d2_valid;
   logic [Q2_BITS-1:0]      d2_quot;
   tag_type                 d2_tag;

   logic [SAMPLE_WIDTH:0]   mag_fin, mag_sat, res_wide;
   logic                    out_vld_ff;
   logic [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;

   assign in_pop = in_valid;

   // stage 1: alpha * d + span/2
   always_comb begin
      b1_num_in     = NUM1_W'(ALPHA_M) * NUM1_W'(in_diff) + HALF_SPAN;
      b1_tag_in.cls = in_class;
      b1_tag_in.mag = in_mag;
   end

   lcsm_cdiv #(
      .NUM_W   (NUM1_W),
      .QBITS   (ALPHA_W),
      .DIVISOR (SPAN),
      .TAG_W   ($bits(tag_type))
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b1_vld_ff),
      .in_num    (b1_num_ff),
      .in_tag    (b1_tag_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_tag   (d1_tag)
   );

   // stage 2: normalize y = 1 + x, table lookup
   always_comb begin
      y = ONE_Y + FRAC_BITS'(d1_quot);
      priority if (y[FRAC_BITS-1]) begin
         exp_in = 2'd3;
         frac   = {y[FRAC_BITS-2:0], 1'b0};
      end else if (y[FRAC_BITS-2]) begin
         exp_in = 2'd2;
         frac   = {y[FRAC_BITS-3:0], 2'b0};
      end else if (y[FRAC_BITS-3]) begin
         exp_in = 2'd1;
         frac   = {y[FRAC_BITS-4:0], 3'b0};
      end else begin
         exp_in = 2'd0;
         frac   = {y[FRAC_BITS-5:0], 4'b0};
      end
      idx_lo = {1'b0, frac[FRAC_BITS-1 -: LOG_TABLE_BITS]};
      idx_hi = idx_lo + 1'b1;
      lo_in  = log_tab[idx_lo];
      hi_in  = log_tab[idx_hi];
   end

   // stage 4 and 5
   always_comb begin
      b4_lg_in  = LG_W'({b3_exp_ff, 16'd0}) + LG_W'(b3_lo_ff) + LG_W'(b3_prod_ff >> REM_BITS);
      b5_num_in = NUM2_W'(HEAD_M) * NUM2_W'(b4_lg_ff) + HALF_LGMAX;
   end

   lcsm_cdiv #(
      .NUM_W   (NUM2_W),
      .QBITS   (Q2_BITS),
      .DIVISOR (64'(LGMAX)),
      .TAG_W   ($bits(tag_type))
   ) u_div_m (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b5_vld_ff),
      .in_num    (b5_num_ff),
      .in_tag    (b5_tag_ff),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_tag   (d2_tag)
   );

   // final: rebuild magnitude, saturate, apply sign
   always_comb begin
      mag_fin = d2_tag.cls.comp ? THRESH_M + (SAMPLE_WIDTH+1)'(d2_quot) : d2_tag.mag;
      if (d2_tag.cls.neg) begin
         mag_sat  = (mag_fin > FULL_M) ? FULL_M : mag_fin;
         res_wide = (SAMPLE_WIDTH+1)'(0) - mag_sat;
      end else begin
         mag_sat  = (mag_fin > POS_MAX) ? POS_MAX : mag_fin;
         res_wide = mag_sat;
      end
      out_sample_in = res_wide[SAMPLE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         b3_vld_ff  <= 1'b0;
         b4_vld_ff  <= 1'b0;
         b5_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         b1_vld_ff  <= in_valid;
         b2_vld_ff  <= d1_valid;
         b3_vld_ff  <= b2_vld_ff;
         b4_vld_ff  <= b3_vld_ff;
         b5_vld_ff  <= b4_vld_ff;
         out_vld_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      b1_num_ff     <= b1_num_in;
      b1_tag_ff     <= b1_tag_in;
      b2_exp_ff     <= exp_in;
      b2_lo_ff      <= lo_in;
      b2_slope_ff   <= hi_in - lo_in;
      b2_rem_ff     <= frac[REM_BITS-1:0];
      b2_tag_ff     <= d1_tag;
      b3_exp_ff     <= b2_exp_ff;
      b3_lo_ff      <= b2_lo_ff;
      b3_prod_ff    <= PROD_W'(b2_slope_ff) * PROD_W'(b2_rem_ff);
      b3_tag_ff     <= b2_tag_ff;
      b4_lg_ff      <= b4_lg_in;
      b4_tag_ff     <= b3_tag_ff;
      b5_num_ff     <= b5_num_in;
      b5_tag_ff     <= b4_tag_ff;
      out_sample_ff <= out_sample_in;
   end

   assign out_valid  = out_vld_ff;
   assign out_sample = out_sample_ff;

   `LCSM_ASSERT_IMP(a_x_range, d1_valid, d1_quot <= ALPHA_M)
   `LCSM_ASSERT_IMP(a_head_range, d2_valid && d2_tag.cls.comp, d2_quot <= HEAD_M)
   `LCSM_ASSERT_NEXT(a_pop_taken, in_valid, b1_vld_ff)

endmodule
`default_nettype wire

@@ sv/log_compressed_sample_mixer.sv @@
// A beat passes the two front stages, one queue slot and the back pipeline, which holds two dividers.
// Throughput: one beat per clock, every stage advances each cycle.
// busy rises only when the front-to-back queue is full; the back never stalls, so it stays low.
// Reset (synchronous, active high) clears all valid flags and queue pointers;
// beats in flight are dropped.
`default_nettype none
module log_compressed_sample_mixer
   import lcsm_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_acc_sample,
   input  logic                           req_acc_present,
   input  logic signed [SAMPLE_WIDTH-1:0] req_source_sample,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_mixed_sample
);

   typedef struct packed {
      lcsm_class_type          cls;
      logic [SAMPLE_WIDTH:0]   mag;
      logic [SAMPLE_WIDTH-1:0] diff;
   } item_type;

   item_type f_item, q_item;
   logic     f_valid, q_full, q_valid, q_pop;
   logic [SAMPLE_WIDTH-1:0] b_sample;

   lcsm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_acc_sample    (req_acc_sample),
      .req_acc_present   (req_acc_present),
      .req_source_sample (req_source_sample),
      .out_valid         (f_valid),
      .out_class         (f_item.cls),
      .out_mag           (f_item.mag),
      .out_diff          (f_item.diff),
      .out_full          (q_full)
   );

   lcsm_queue #(
      .WIDTH ($bits(item_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_data   (f_item),
      .full      (q_full),
      .out_valid (q_valid),
      .out_data  (q_item),
      .out_pop   (q_pop)
   );

   lcsm_back #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_class   (q_item.cls),
      .in_mag     (q_item.mag),
      .in_diff    (q_item.diff),
      .in_pop     (q_pop),
      .out_valid  (rsp_valid),
      .out_sample (b_sample)
   );

   assign rsp_mixed_sample = $signed(b_sample);

endmodule
`default_nettype wire
